>>> src/tcp_connection_tracking_table_unit_defines.svh
// Assertion macros used by the top-level unit to check this block.
`ifndef TCP_CONNECTION_TRACKING_TABLE_UNIT_DEFINES_SVH
`define TCP_CONNECTION_TRACKING_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TCPCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TCPCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/tcpct_pkg.sv
package tcpct_pkg;

  localparam int unsigned SockKeyW = 64;
  localparam int unsigned DestKeyW = 56;

  localparam logic [3:0] StateEstablished = 4'd1;
  localparam logic [3:0] StateClose       = 4'd7;

  // Operation broadcast to the cells for the item under scan.
  typedef enum logic [1:0] {
    OP_NONE  = 2'b00,
    OP_CLOSE = 2'b01,
    OP_OPEN  = 2'b10
  } op_e;

  // Scan token for the socket chain.
  typedef struct packed {
    logic active;
    logic hit;
  } sock_tok_t;

  // Scan token for the destination chain.
  typedef struct packed {
    logic active;
    logic found;
    logic stored;
  } dest_tok_t;

endpackage

>>> src/tcpct_evt_if.sv
interface tcpct_evt_if import tcpct_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SockKeyW-1:0] socket_id;
  logic [3:0]          new_state;
  logic [31:0]         dest_addr;
  logic [15:0]         dest_port;
  logic [7:0]          proto;
  logic                passive_open;

  modport source (
    output valid, socket_id, new_state, dest_addr, dest_port, proto, passive_open,
    input  ready
  );

  modport sink (
    input  valid, socket_id, new_state, dest_addr, dest_port, proto, passive_open,
    output ready
  );
endinterface

>>> src/tcpct_res_if.sv
interface tcpct_res_if;
  logic valid;
  logic ready;
  logic conn_opened;
  logic conn_closed;
  logic new_destination;
  logic report_passive;
  logic socket_table_full;
  logic dest_table_full;

  modport source (
    output valid, conn_opened, conn_closed, new_destination, report_passive,
           socket_table_full, dest_table_full,
    input  ready
  );

  modport sink (
    input  valid, conn_opened, conn_closed, new_destination, report_passive,
           socket_table_full, dest_table_full,
    output ready
  );
endinterface

>>> src/tcpct_sock_cell.sv
module tcpct_sock_cell import tcpct_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  op_e                 op_i,
  input  logic [SockKeyW-1:0] key_i,
  input  sock_tok_t           tok_i,
  output sock_tok_t           tok_o
);

  logic                valid_q, valid_d;
  logic [SockKeyW-1:0] key_q;
  logic                key_we;
  sock_tok_t           tok_q, tok_d;

  always_comb begin
    valid_d = valid_q;
    key_we  = 1'b0;
    tok_d   = tok_i;
    // Only the first cell that takes the token acts on it.
    if (tok_i.active && !tok_i.hit) begin
      case (op_i)
        OP_CLOSE: begin
          if (valid_q && (key_q == key_i)) begin
            valid_d   = 1'b0;
            tok_d.hit = 1'b1;
          end
        end
        OP_OPEN: begin
          if (!valid_q) begin
            valid_d   = 1'b1;
            key_we    = 1'b1;
            tok_d.hit = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_q <= key_i;
    end
  end

  assign tok_o = tok_q;

endmodule

>>> src/tcpct_dest_cell.sv
module tcpct_dest_cell import tcpct_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  op_e                 op_i,
  input  logic [DestKeyW-1:0] key_i,
  input  dest_tok_t           tok_i,
  output dest_tok_t           tok_o
);

  logic                valid_q, valid_d;
  logic [DestKeyW-1:0] key_q;
  logic                key_we;
  dest_tok_t           tok_q, tok_d;

  // Entries are never freed and always fill the lowest free cell, so valid
  // cells form a prefix: a match always lies ahead of the first free cell.
  always_comb begin
    valid_d = valid_q;
    key_we  = 1'b0;
    tok_d   = tok_i;
    if (tok_i.active && (op_i == OP_OPEN) && !tok_i.found && !tok_i.stored) begin
      if (valid_q) begin
        if (key_q == key_i) begin
          tok_d.found = 1'b1;
        end
      end else begin
        valid_d      = 1'b1;
        key_we       = 1'b1;
        tok_d.stored = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_q <= key_i;
    end
  end

  assign tok_o = tok_q;

endmodule

>>> src/tcp_connection_tracking_table_unit.sv
// Channel | Dir | Interface     | Payload
// evt_i   | in  | tcpct_evt_if  | socket_id, new_state, dest_addr, dest_port, proto,
//         |     |               | passive_open
// res_o   | out | tcpct_res_if  | conn_opened, conn_closed, new_destination,
//         |     |               | report_passive, socket_table_full, dest_table_full
//
// One item is in work at a time; the next item is accepted once the current result is
// loaded into the output register. The scan token walks one cell of each chain per cycle.
// Reset clears every valid bit at once; no clearing pass.
// A result waits in the output register while the next item is accepted; a scan
// that finishes while that register is full holds until it drains.
`include "tcp_connection_tracking_table_unit_defines.svh"

module tcp_connection_tracking_table_unit import tcpct_pkg::*; #(
  parameter int unsigned SOCKET_ENTRIES = 256,
  parameter int unsigned DEST_ENTRIES   = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcpct_evt_if.sink   evt_i,
  tcpct_res_if.source res_o
);

  logic                busy_q, launch_q;
  op_e                 op_q;
  logic [SockKeyW-1:0] sock_key_q;
  logic [DestKeyW-1:0] dest_key_q;
  logic                passive_q;

  logic sock_fin_q, sock_hit_q;
  logic dest_fin_q, dest_found_q, dest_stored_q;

  logic out_valid_q;
  logic opened_q, closed_q, newdest_q, passive_out_q, sfull_q, dfull_q;

  logic evt_acc, res_load;
  op_e  evt_op;

  sock_tok_t sock_tok [SOCKET_ENTRIES+1];
  dest_tok_t dest_tok [DEST_ENTRIES+1];

  assign evt_i.ready = !busy_q;
  assign evt_acc     = evt_i.valid && !busy_q;
  assign res_load    = busy_q && sock_fin_q && dest_fin_q && (!out_valid_q || res_o.ready);

  always_comb begin
    case (evt_i.new_state)
      StateClose:       evt_op = OP_CLOSE;
      StateEstablished: evt_op = OP_OPEN;
      default:          evt_op = OP_NONE;
    endcase
  end

  // Item held for the whole scan; the cells see it as a broadcast.
  always_ff @(posedge clk_i) begin
    if (evt_acc) begin
      op_q       <= evt_op;
      sock_key_q <= evt_i.socket_id;
      dest_key_q <= {evt_i.dest_addr, evt_i.dest_port, evt_i.proto};
      passive_q  <= evt_i.passive_open;
    end
  end

  assign sock_tok[0] = '{active: launch_q, hit: 1'b0};
  assign dest_tok[0] = '{active: launch_q, found: 1'b0, stored: 1'b0};

  for (genvar g = 0; g < SOCKET_ENTRIES; g++) begin : g_sock
    tcpct_sock_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .op_i   (op_q),
      .key_i  (sock_key_q),
      .tok_i  (sock_tok[g]),
      .tok_o  (sock_tok[g+1])
    );
  end

  for (genvar g = 0; g < DEST_ENTRIES; g++) begin : g_dest
    tcpct_dest_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .op_i   (op_q),
      .key_i  (dest_key_q),
      .tok_i  (dest_tok[g]),
      .tok_o  (dest_tok[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      launch_q      <= 1'b0;
      sock_fin_q    <= 1'b0;
      sock_hit_q    <= 1'b0;
      dest_fin_q    <= 1'b0;
      dest_found_q  <= 1'b0;
      dest_stored_q <= 1'b0;
    end else begin
      launch_q <= evt_acc;
      if (evt_acc) begin
        busy_q     <= 1'b1;
        sock_fin_q <= 1'b0;
        dest_fin_q <= 1'b0;
      end else if (res_load) begin
        busy_q <= 1'b0;
      end
      // Catch each token as it leaves the end of its chain.
      if (sock_tok[SOCKET_ENTRIES].active) begin
        sock_fin_q <= 1'b1;
        sock_hit_q <= sock_tok[SOCKET_ENTRIES].hit;
      end
      if (dest_tok[DEST_ENTRIES].active) begin
        dest_fin_q    <= 1'b1;
        dest_found_q  <= dest_tok[DEST_ENTRIES].found;
        dest_stored_q <= dest_tok[DEST_ENTRIES].stored;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      opened_q      <= (op_q == OP_OPEN) && sock_hit_q;
      sfull_q       <= (op_q == OP_OPEN) && !sock_hit_q;
      closed_q      <= (op_q == OP_CLOSE) && sock_hit_q;
      newdest_q     <= (op_q == OP_OPEN) && dest_stored_q;
      dfull_q       <= (op_q == OP_OPEN) && !dest_stored_q && !dest_found_q;
      passive_out_q <= passive_q;
    end
  end

  assign res_o.valid             = out_valid_q;
  assign res_o.conn_opened       = opened_q;
  assign res_o.conn_closed       = closed_q;
  assign res_o.new_destination   = newdest_q;
  assign res_o.report_passive    = passive_out_q;
  assign res_o.socket_table_full = sfull_q;
  assign res_o.dest_table_full   = dfull_q;

  `TCPCT_ASSERT_NOW(a_tok_while_busy, sock_tok[SOCKET_ENTRIES].active || dest_tok[DEST_ENTRIES].active, busy_q, "scan token left a chain while no item was in work")
  `TCPCT_ASSERT_NEXT(a_load_frees_input, res_load, !busy_q && out_valid_q, "result load did not free the input side")
  `TCPCT_ASSERT_NOW(a_open_close_excl, out_valid_q, !(opened_q && closed_q) && !(opened_q && sfull_q), "conflicting socket flags in result")
  `TCPCT_ASSERT_NOW(a_dest_excl, out_valid_q, !(newdest_q && dfull_q), "new destination and destination full both set")

endmodule
